// ===== design/srga_pkg.sv =====
// shared types and constants of the send rate gap adjuster
package srga_pkg;

    localparam int RATE_W     = 40;
    localparam int PREC_W     = 16;
    localparam int GAP_W      = 32;
    localparam int RATIO_W    = 24;
    localparam int HIT_W      = 8;
    localparam int SUM_W      = 32;
    localparam int PROD_W     = 64;
    localparam int OUT_W      = 72;
    localparam int CFG_IDX_W  = 2;
    localparam int CFG_DATA_W = 40;

    localparam logic [CFG_IDX_W-1:0] REG_TARGET_RATE = 2'd0;
    localparam logic [CFG_IDX_W-1:0] REG_PRECISION   = 2'd1;
    localparam logic [CFG_IDX_W-1:0] REG_START_GAP   = 2'd2;

    localparam logic [RATE_W-1:0]  TARGET_RATE_RST = 40'd1000000000;
    localparam logic [PREC_W-1:0]  PRECISION_RST   = 16'd3277;
    localparam logic [GAP_W-1:0]   START_GAP_RST   = 32'd1000;
    localparam logic [RATIO_W-1:0] RATIO_MAX       = 24'hFFFFFF;
    localparam logic [HIT_W-1:0]   HIT_MAX         = 8'hFF;
    localparam logic [GAP_W-1:0]   GAP_MAX         = 32'hFFFFFFFF;
    localparam logic [SUM_W-1:0]   SUM_MAX         = 32'hFFFFFFFF;

    typedef struct packed {
        logic load_num;
        logic load_mean;
        logic div_step;
        logic check;
        logic eval;
        logic mult;
        logic scale;
        logic commit;
    } srga_cmd_t;

    typedef struct packed {
        logic hit;
        logic have_hits;
    } srga_sts_t;

endpackage

// ===== design/srga_datapath.sv =====
// datapath: configuration registers, shared restoring divider, multiplier, state and result
module srga_datapath #(
    parameter int HITS_NEEDED     = 4,
    parameter int RATIO_FRAC_BITS = 16
) (
    input  logic                               aclk,
    input  logic                               aresetn,
    input  srga_pkg::srga_cmd_t                cmd,
    output srga_pkg::srga_sts_t                sts,
    input  logic [srga_pkg::RATE_W-1:0]        in_rate,
    input  logic                               cfg_we,
    input  logic [srga_pkg::CFG_IDX_W-1:0]     cfg_index,
    input  logic [srga_pkg::CFG_DATA_W-1:0]    cfg_data,
    output logic [srga_pkg::OUT_W-1:0]         out_data
);
    import srga_pkg::*;

    localparam int NW = RATE_W + RATIO_FRAC_BITS;
    localparam int CW = 41;
    localparam logic [RATIO_W:0] ONE = (RATIO_W+1)'(1) << RATIO_FRAC_BITS;

    logic [RATE_W-1:0]  target_reg;
    logic [PREC_W-1:0]  prec_reg;
    logic [GAP_W-1:0]   gap_reg;
    logic [HIT_W-1:0]   hits_reg;
    logic [SUM_W-1:0]   sum_reg;
    logic [NW-1:0]      num_reg;
    logic [RATE_W-1:0]  rem_reg;
    logic [RATE_W-1:0]  dvs_reg;
    logic [RATIO_W-1:0] ratio_reg;
    logic               hit_reg;
    logic [PROD_W-1:0]  prod_reg;
    logic [GAP_W-1:0]   new_gap_reg;
    logic [OUT_W-1:0]   out_reg;

    logic [RATE_W:0]    rs;
    logic               ge;
    logic [RATE_W:0]    rs_sub;
    logic               sat;
    logic [RATIO_W:0]   dev;
    logic [CW-1:0]      dev_sh;
    logic [CW-1:0]      prec_sh;
    logic               hit_comb;
    logic [SUM_W-1:0]   factor;
    logic [PROD_W-1:0]  prod_sh;
    logic [SUM_W:0]     sum_add;
    logic [GAP_W-1:0]   gap_next;
    logic [HIT_W-1:0]   hits_next;
    logic [SUM_W-1:0]   sum_next;
    logic               conv;

    // divider step
    assign rs     = {rem_reg, num_reg[NW-1]};
    assign ge     = rs >= {1'b0, dvs_reg};
    assign rs_sub = rs - {1'b0, dvs_reg};

    // ratio saturation and precision window
    assign sat      = (target_reg == '0) || (|num_reg[NW-1:RATIO_W]);
    assign dev      = ({1'b0, ratio_reg} >= ONE) ? ({1'b0, ratio_reg} - ONE)
                                                 : (ONE - {1'b0, ratio_reg});
    assign dev_sh   = {dev, 16'd0};
    assign prec_sh  = CW'(prec_reg) << RATIO_FRAC_BITS;
    assign hit_comb = dev_sh < prec_sh;

    assign sts.hit       = hit_comb;
    assign sts.have_hits = hits_reg != '0;

    assign factor  = (hits_reg != '0) ? num_reg[SUM_W-1:0] : SUM_W'(ratio_reg);
    assign prod_sh = prod_reg >> RATIO_FRAC_BITS;
    assign sum_add = {1'b0, sum_reg} + (SUM_W+1)'(ratio_reg);

    always_comb begin
        gap_next  = gap_reg;
        hits_next = hits_reg;
        sum_next  = sum_reg;
        if (hit_reg) begin
            if (hits_reg != HIT_MAX) begin
                hits_next = hits_reg + 1'b1;
                sum_next  = sum_add[SUM_W] ? SUM_MAX : sum_add[SUM_W-1:0];
            end
        end else begin
            gap_next  = new_gap_reg;
            hits_next = '0;
            sum_next  = '0;
        end
    end

    assign conv = hits_next >= HIT_W'(HITS_NEEDED);

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            target_reg <= TARGET_RATE_RST;
            prec_reg   <= PRECISION_RST;
            gap_reg    <= START_GAP_RST;
            hits_reg   <= '0;
            sum_reg    <= '0;
        end else begin
            if (cmd.commit) begin
                gap_reg  <= gap_next;
                hits_reg <= hits_next;
                sum_reg  <= sum_next;
            end
            if (cfg_we) begin
                case (cfg_index)
                    REG_TARGET_RATE: target_reg <= cfg_data[RATE_W-1:0];
                    REG_PRECISION:   prec_reg   <= cfg_data[PREC_W-1:0];
                    REG_START_GAP:   gap_reg    <= cfg_data[GAP_W-1:0];
                    default: ;
                endcase
            end
        end
    end

    always_ff @(posedge aclk) begin
        if (cmd.load_num) begin
            num_reg <= {in_rate, {RATIO_FRAC_BITS{1'b0}}};
            rem_reg <= '0;
            dvs_reg <= target_reg;
        end else if (cmd.load_mean) begin
            num_reg <= {sum_reg, {(NW-SUM_W){1'b0}}};
            rem_reg <= '0;
            dvs_reg <= RATE_W'(hits_reg);
        end else if (cmd.div_step) begin
            num_reg <= {num_reg[NW-2:0], ge};
            rem_reg <= ge ? rs_sub[RATE_W-1:0] : rs[RATE_W-1:0];
        end
        if (cmd.check) begin
            ratio_reg <= sat ? RATIO_MAX : num_reg[RATIO_W-1:0];
        end
        if (cmd.eval) begin
            hit_reg <= hit_comb;
        end
        if (cmd.mult) begin
            prod_reg <= PROD_W'(gap_reg) * PROD_W'(factor);
        end
        if (cmd.scale) begin
            new_gap_reg <= (|prod_sh[PROD_W-1:GAP_W]) ? GAP_MAX : prod_sh[GAP_W-1:0];
        end
        if (cmd.commit) begin
            out_reg <= {6'd0, conv, hits_next, hit_reg, ratio_reg, gap_next};
        end
    end

    assign out_data = out_reg;

endmodule

// ===== design/srga_ctrl.sv =====
// controller state machine: sequences the divider, multiplier and result hand-off
module srga_ctrl #(
    parameter int RATIO_FRAC_BITS = 16
) (
    input  logic                aclk,
    input  logic                aresetn,
    input  logic                s_tvalid,
    output logic                s_tready,
    output logic                m_tvalid,
    input  logic                m_tready,
    output srga_pkg::srga_cmd_t cmd,
    input  srga_pkg::srga_sts_t sts
);
    import srga_pkg::*;

    localparam int NW    = RATE_W + RATIO_FRAC_BITS;
    localparam int CNT_W = $clog2(NW);

    localparam logic [2:0] S_IDLE  = 3'd0;
    localparam logic [2:0] S_RDIV  = 3'd1;
    localparam logic [2:0] S_CHECK = 3'd2;
    localparam logic [2:0] S_EVAL  = 3'd3;
    localparam logic [2:0] S_MDIV  = 3'd4;
    localparam logic [2:0] S_MUL   = 3'd5;
    localparam logic [2:0] S_SCALE = 3'd6;
    localparam logic [2:0] S_DONE  = 3'd7;

    logic [2:0]       state_reg, state_next;
    logic [CNT_W-1:0] cnt_reg, cnt_next;
    logic             valid_reg, valid_next;

    assign s_tready = state_reg == S_IDLE;
    assign m_tvalid = valid_reg;

    always_comb begin
        state_next = state_reg;
        cnt_next   = cnt_reg;
        cmd        = '0;
        case (state_reg)
            S_IDLE: begin
                if (s_tvalid) begin
                    cmd.load_num = 1'b1;
                    cnt_next     = '0;
                    state_next   = S_RDIV;
                end
            end
            S_RDIV: begin
                cmd.div_step = 1'b1;
                cnt_next     = cnt_reg + 1'b1;
                if (cnt_reg == CNT_W'(NW - 1)) begin
                    state_next = S_CHECK;
                end
            end
            S_CHECK: begin
                cmd.check  = 1'b1;
                state_next = S_EVAL;
            end
            S_EVAL: begin
                cmd.eval = 1'b1;
                if (sts.hit) begin
                    state_next = S_DONE;
                end else if (sts.have_hits) begin
                    cmd.load_mean = 1'b1;
                    cnt_next      = '0;
                    state_next    = S_MDIV;
                end else begin
                    state_next = S_MUL;
                end
            end
            S_MDIV: begin
                cmd.div_step = 1'b1;
                cnt_next     = cnt_reg + 1'b1;
                if (cnt_reg == CNT_W'(SUM_W - 1)) begin
                    state_next = S_MUL;
                end
            end
            S_MUL: begin
                cmd.mult   = 1'b1;
                state_next = S_SCALE;
            end
            S_SCALE: begin
                cmd.scale  = 1'b1;
                state_next = S_DONE;
            end
            S_DONE: begin
                if (!valid_reg || m_tready) begin
                    cmd.commit = 1'b1;
                    state_next = S_IDLE;
                end
            end
            default: begin
                state_next = S_IDLE;
            end
        endcase
    end

    always_comb begin
        valid_next = valid_reg;
        if (cmd.commit) begin
            valid_next = 1'b1;
        end else if (m_tready) begin
            valid_next = 1'b0;
        end
    end

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            state_reg <= S_IDLE;
            cnt_reg   <= '0;
            valid_reg <= 1'b0;
        end else begin
            state_reg <= state_next;
            cnt_reg   <= cnt_next;
            valid_reg <= valid_next;
        end
    end

endmodule

// ===== design/send_rate_gap_adjuster_core.sv =====
// top level of the send rate gap adjuster
//
// s_ channel: one throughput report per transfer, measured rate in bits per second.
// m_ channel: one result per report: new packet gap, rate ratio (unsigned, 24 bits,
// RATIO_FRAC_BITS fraction bits), in-range flag, hit count and converged flag.
// cfg channel: register writes (target rate, precision, start gap), always ready;
// write only while no report is in flight. Writing the start gap also loads the gap.
// Each report runs the ratio divide, a check and an evaluation; an out-of-range report
// then multiplies and scales the gap, preceded by a divide for the mean of earlier hits
// when there are any (32-step divide). The restoring divider produces one quotient bit
// per cycle; one item is taken at a time, so a new report is accepted in the cycle
// after the previous result is loaded.
// The result sits in an output register: the next report is accepted while it waits,
// and the block holds in its final step until the receiver takes the previous result.
// Reset (synchronous, active low) restores register defaults, gap 1000, clears hits,
// sum and the output valid.
module send_rate_gap_adjuster_core #(
    parameter int HITS_NEEDED     = 4,
    parameter int RATIO_FRAC_BITS = 16
) (
    input  logic                            aclk,
    input  logic                            aresetn,
    input  logic                            s_tvalid,
    output logic                            s_tready,
    // measured_rate [39:0]
    input  logic [srga_pkg::RATE_W-1:0]     s_tdata,
    output logic                            m_tvalid,
    input  logic                            m_tready,
    // gap [31:0], ratio [55:32], in_range [56], hit_count [64:57],
    // converged [65], zero pad [71:66]
    output logic [srga_pkg::OUT_W-1:0]      m_tdata,
    input  logic                            cfg_valid,
    output logic                            cfg_ready,
    input  logic [srga_pkg::CFG_IDX_W-1:0]  cfg_index,
    input  logic [srga_pkg::CFG_DATA_W-1:0] cfg_data
);
    import srga_pkg::*;

    srga_cmd_t cmd;
    srga_sts_t sts;

    assign cfg_ready = 1'b1;

    srga_ctrl #(
        .RATIO_FRAC_BITS (RATIO_FRAC_BITS)
    ) u_ctrl (
        .aclk     (aclk),
        .aresetn  (aresetn),
        .s_tvalid (s_tvalid),
        .s_tready (s_tready),
        .m_tvalid (m_tvalid),
        .m_tready (m_tready),
        .cmd      (cmd),
        .sts      (sts)
    );

    srga_datapath #(
        .HITS_NEEDED     (HITS_NEEDED),
        .RATIO_FRAC_BITS (RATIO_FRAC_BITS)
    ) u_datapath (
        .aclk      (aclk),
        .aresetn   (aresetn),
        .cmd       (cmd),
        .sts       (sts),
        .in_rate   (s_tdata),
        .cfg_we    (cfg_valid & cfg_ready),
        .cfg_index (cfg_index),
        .cfg_data  (cfg_data),
        .out_data  (m_tdata)
    );

endmodule

// ===== bench/tb_send_rate_gap_adjuster_core.sv =====
// testbench of send_rate_gap_adjuster_core: directed rows, then random reports checked by a predictor
module tb_send_rate_gap_adjuster_core;
    timeunit 1ns;
    timeprecision 1ps;

    import srga_pkg::*;

    localparam int HITS_NEEDED  = 4;
    localparam int RATIO_FRAC   = 16;
    localparam int SETTLE       = 4;
    localparam int TAIL_CYCLES  = 200;
    localparam int PHASE_ITEMS  = 630;
    localparam logic [63:0] UNITY = 64'd1 << RATIO_FRAC;
    localparam logic [CFG_IDX_W-1:0] REG_UNUSED = 2'd3;

    typedef struct packed {
        logic [GAP_W-1:0]   gap;
        logic [RATIO_W-1:0] ratio;
        logic               in_range;
        logic [HIT_W-1:0]   hits;
        logic               conv;
    } gap_result_t;

    typedef enum logic {ROW_REPORT, ROW_WRITE} row_kind_t;

    typedef struct packed {
        row_kind_t              kind;
        logic [CFG_IDX_W-1:0]   idx;
        logic [CFG_DATA_W-1:0]  data;
        logic                   typed;
        gap_result_t            res;
    } dir_row_t;

    localparam gap_result_t NO_EXP = '0;
    localparam int N_DIR = 29;

    localparam dir_row_t DIR_ROWS [N_DIR] = '{
        '{ROW_REPORT, '0, 40'd1000000000, 1'b1, '{32'd1000, 24'h010000, 1'b1, 8'd1, 1'b0}},
        '{ROW_REPORT, '0, 40'd1000000000, 1'b1, '{32'd1000, 24'h010000, 1'b1, 8'd2, 1'b0}},
        '{ROW_REPORT, '0, 40'd1000000000, 1'b1, '{32'd1000, 24'h010000, 1'b1, 8'd3, 1'b0}},
        '{ROW_REPORT, '0, 40'd1000000000, 1'b1, '{32'd1000, 24'h010000, 1'b1, 8'd4, 1'b1}},
        '{ROW_REPORT, '0, 40'd0, 1'b1, '{32'd1000, 24'h000000, 1'b0, 8'd0, 1'b0}},
        '{ROW_REPORT, '0, 40'd0, 1'b1, '{32'd0, 24'h000000, 1'b0, 8'd0, 1'b0}},
        '{ROW_WRITE, REG_START_GAP, 40'hFFFFFFFF, 1'b0, NO_EXP},
        '{ROW_REPORT, '0, 40'hFFFFFFFFFF, 1'b1, '{32'hFFFFFFFF, 24'hFFFFFF, 1'b0, 8'd0, 1'b0}},
        // zero target saturates the ratio
        '{ROW_WRITE, REG_TARGET_RATE, 40'd0, 1'b0, NO_EXP},
        '{ROW_REPORT, '0, 40'd12345, 1'b1, '{32'hFFFFFFFF, 24'hFFFFFF, 1'b0, 8'd0, 1'b0}},
        '{ROW_WRITE, REG_TARGET_RATE, 40'hFFFFFFFFFF, 1'b0, NO_EXP},
        '{ROW_REPORT, '0, 40'hFFFFFFFFFF, 1'b1, '{32'hFFFFFFFF, 24'h010000, 1'b1, 8'd1, 1'b0}},
        // target of one in ratio units: ratio equals the measured rate
        '{ROW_WRITE, REG_TARGET_RATE, 40'd65536, 1'b0, NO_EXP},
        '{ROW_WRITE, REG_START_GAP, 40'd1000, 1'b0, NO_EXP},
        // precision edges, strict compare
        '{ROW_REPORT, '0, 40'd68812, 1'b1, '{32'd1000, 24'h010CCC, 1'b1, 8'd2, 1'b0}},
        '{ROW_REPORT, '0, 40'd62260, 1'b1, '{32'd1000, 24'h00F334, 1'b1, 8'd3, 1'b0}},
        '{ROW_REPORT, '0, 40'd68813, 1'b1, '{32'd1000, 24'h010CCD, 1'b0, 8'd0, 1'b0}},
        '{ROW_REPORT, '0, 40'd62259, 1'b0, NO_EXP},
        // zero precision never hits
        '{ROW_WRITE, REG_PRECISION, 40'd0, 1'b0, NO_EXP},
        '{ROW_REPORT, '0, 40'd65536, 1'b0, NO_EXP},
        '{ROW_WRITE, REG_PRECISION, 40'hFFFF, 1'b0, NO_EXP},
        '{ROW_REPORT, '0, 40'd1, 1'b0, NO_EXP},
        '{ROW_REPORT, '0, 40'd2, 1'b0, NO_EXP},
        '{ROW_REPORT, '0, 40'd131071, 1'b0, NO_EXP},
        '{ROW_WRITE, REG_TARGET_RATE, 40'd1, 1'b0, NO_EXP},
        '{ROW_REPORT, '0, 40'd255, 1'b0, NO_EXP},
        '{ROW_REPORT, '0, 40'd256, 1'b0, NO_EXP},
        // unknown register index is ignored
        '{ROW_WRITE, REG_UNUSED, 40'hA5A5A5A5A5, 1'b0, NO_EXP},
        '{ROW_REPORT, '0, 40'd1, 1'b0, NO_EXP}
    };

    logic                  aclk;
    logic                  aresetn   = 1'b0;
    logic                  s_tvalid  = 1'b0;
    logic                  s_tready;
    logic [RATE_W-1:0]     s_tdata   = '0;
    logic                  m_tvalid;
    logic                  m_tready  = 1'b0;
    logic [OUT_W-1:0]      m_tdata;
    logic                  cfg_valid = 1'b0;
    logic                  cfg_ready;
    logic [CFG_IDX_W-1:0]  cfg_index = '0;
    logic [CFG_DATA_W-1:0] cfg_data  = '0;

    // predictor copy of registers and state
    logic [RATE_W-1:0] cfg_target = TARGET_RATE_RST;
    logic [PREC_W-1:0] cfg_prec   = PRECISION_RST;
    logic [GAP_W-1:0]  gap_now    = START_GAP_RST;
    logic [HIT_W-1:0]  hit_now    = '0;
    logic [SUM_W-1:0]  sum_now    = '0;

    gap_result_t pending_results [$];
    int unsigned mismatch_count = 0;
    int unsigned n_sent = 0;
    int unsigned tx_idle_pct = 8;
    int unsigned rx_idle_pct = 79;

    send_rate_gap_adjuster_core #(
        .HITS_NEEDED     (HITS_NEEDED),
        .RATIO_FRAC_BITS (RATIO_FRAC)
    ) uut (
        .aclk      (aclk),
        .aresetn   (aresetn),
        .s_tvalid  (s_tvalid),
        .s_tready  (s_tready),
        .s_tdata   (s_tdata),
        .m_tvalid  (m_tvalid),
        .m_tready  (m_tready),
        .m_tdata   (m_tdata),
        .cfg_valid (cfg_valid),
        .cfg_ready (cfg_ready),
        .cfg_index (cfg_index),
        .cfg_data  (cfg_data)
    );

    initial begin
        aclk = 1'b0;
        forever #6 aclk = ~aclk;
    end

    initial begin
        #40_000_000;
        $display("tb_send_rate_gap_adjuster_core: done, errors");
        $finish;
    end

    function automatic void apply_write(input logic [CFG_IDX_W-1:0] idx,
                                        input logic [CFG_DATA_W-1:0] data);
        case (idx)
            REG_TARGET_RATE: cfg_target = data[RATE_W-1:0];
            REG_PRECISION:   cfg_prec = data[PREC_W-1:0];
            REG_START_GAP:   gap_now = data[GAP_W-1:0];
            default: ;
        endcase
    endfunction

    function automatic gap_result_t adjust_gap(input logic [RATE_W-1:0] rate);
        logic [63:0]        m, t, quo, dev, factor, prod;
        logic [SUM_W:0]     acc;
        logic [RATIO_W-1:0] ratio;
        logic               hit;
        gap_result_t        res;
        m = 64'(rate);
        t = 64'(cfg_target);
        if (t == 0 || m >= (t << (RATIO_W - RATIO_FRAC))) begin
            ratio = RATIO_MAX;
        end else begin
            quo = (m << RATIO_FRAC) / t;
            ratio = quo[RATIO_W-1:0];
        end
        dev = (64'(ratio) >= UNITY) ? 64'(ratio) - UNITY : UNITY - 64'(ratio);
        hit = (dev << 16) < (64'(cfg_prec) << RATIO_FRAC);
        if (hit) begin
            if (hit_now != HIT_MAX) begin
                acc = (SUM_W+1)'(sum_now) + (SUM_W+1)'(ratio);
                hit_now = hit_now + 1'b1;
                sum_now = acc[SUM_W] ? SUM_MAX : acc[SUM_W-1:0];
            end
        end else begin
            // mean of earlier hits, or the ratio itself with none
            factor = (hit_now != 0) ? 64'(sum_now) / 64'(hit_now) : 64'(ratio);
            prod = (64'(gap_now) * factor) >> RATIO_FRAC;
            gap_now = (prod > 64'(GAP_MAX)) ? GAP_MAX : prod[GAP_W-1:0];
            hit_now = '0;
            sum_now = '0;
        end
        res.gap = gap_now;
        res.ratio = ratio;
        res.in_range = hit;
        res.hits = hit_now;
        res.conv = (hit_now >= HITS_NEEDED);
        return res;
    endfunction

    function automatic logic [RATE_W-1:0] rand40();
        logic [63:0] w;
        w = {$urandom, $urandom};
        return w[RATE_W-1:0];
    endfunction

    function automatic logic [RATE_W-1:0] clamp40(input logic [63:0] v);
        return (v > 64'hFFFFFFFFFF) ? '1 : v[RATE_W-1:0];
    endfunction

    // a rate aimed at a ratio within the precision window (a random rate when the target is zero)
    function automatic logic [RATE_W-1:0] near_one_rate();
        logic [63:0] r;
        int unsigned off;
        off = (cfg_prec == 0) ? 0 : $urandom_range(cfg_prec - 1);
        r = $urandom_range(1) ? UNITY + off : UNITY - off;
        if (cfg_target == 0)
            return rand40();
        return clamp40((64'(cfg_target) * r) >> RATIO_FRAC);
    endfunction

    function automatic logic [RATE_W-1:0] any_rate();
        logic [63:0] r;
        case ($urandom_range(3))
            0: return rand40();
            1: return rand40() >> $urandom_range(39);
            default: begin
                r = 64'($urandom_range(RATIO_MAX));
                return clamp40((64'(cfg_target) * r) >> RATIO_FRAC);
            end
        endcase
    endfunction

    function automatic logic [CFG_DATA_W-1:0] pick_setting(input logic [CFG_IDX_W-1:0] idx);
        logic [CFG_DATA_W-1:0] v;
        v = rand40();
        case (idx)
            REG_TARGET_RATE: case ($urandom_range(7))
                0: v = '0;
                1: v = 40'd1;
                2: v = '1;
                3: v = TARGET_RATE_RST;
                4: v = 40'd65536;
                5: v = 40'($urandom_range(1, 5000));
                6: v = v >> $urandom_range(39);
                default: ;
            endcase
            REG_PRECISION: case ($urandom_range(5))
                0: v = '0;
                1: v = 40'hFFFF;
                2: v = 40'(PRECISION_RST);
                3: v = 40'($urandom_range(1, 16));
                default: ;
            endcase
            REG_START_GAP: case ($urandom_range(5))
                0: v = '0;
                1: v = 40'hFFFFFFFF;
                2: v = 40'(START_GAP_RST);
                3: v = 40'($urandom_range(1, 2000));
                default: ;
            endcase
            default: ;
        endcase
        return v;
    endfunction

    function automatic void check_field(input string name, input logic [63:0] want,
                                        input logic [63:0] got);
        if (want !== got) begin
            $error("%s: expected %0d, got %0d", name, want, got);
            mismatch_count++;
        end
    endfunction

    // result monitor
    always @(posedge aclk) begin
        gap_result_t got, want;
        if (aresetn && m_tvalid && m_tready) begin
            got.gap = m_tdata[31:0];
            got.ratio = m_tdata[55:32];
            got.in_range = m_tdata[56];
            got.hits = m_tdata[64:57];
            got.conv = m_tdata[65];
            if (pending_results.size() == 0) begin
                $error("result transfer with no result outstanding");
                mismatch_count++;
            end else begin
                want = pending_results.pop_front();
                check_field("gap", want.gap, got.gap);
                check_field("ratio", want.ratio, got.ratio);
                check_field("in_range", want.in_range, got.in_range);
                check_field("hit_count", want.hits, got.hits);
                check_field("converged", want.conv, got.conv);
            end
        end
    end

    initial begin
        forever begin
            @(negedge aclk);
            m_tready <= ($urandom_range(99) >= rx_idle_pct);
        end
    end

    // called at a falling edge, returns at a falling edge with tvalid left high
    task automatic send_report(input logic [RATE_W-1:0] rate, input logic typed,
                               input gap_result_t typed_res);
        gap_result_t want;
        if ($urandom_range(99) < tx_idle_pct) begin
            s_tvalid <= 1'b0;
            do begin
                s_tdata <= rand40();
                @(negedge aclk);
            end while ($urandom_range(99) < tx_idle_pct);
        end
        s_tvalid <= 1'b1;
        s_tdata <= rate;
        do @(posedge aclk); while (!s_tready);
        want = adjust_gap(rate);
        pending_results.push_back(typed ? typed_res : want);
        n_sent++;
        @(negedge aclk);
    endtask

    task automatic drain();
        s_tvalid <= 1'b0;
        while (pending_results.size() != 0) @(negedge aclk);
        repeat (SETTLE) @(negedge aclk);
    endtask

    task automatic cfg_write(input logic [CFG_IDX_W-1:0] idx,
                             input logic [CFG_DATA_W-1:0] data);
        cfg_valid <= 1'b1;
        cfg_index <= idx;
        cfg_data <= data;
        do @(posedge aclk); while (!cfg_ready);
        apply_write(idx, data);
        @(negedge aclk);
        cfg_valid <= 1'b0;
        @(negedge aclk);
    endtask

    // drives the hit counter into saturation
    task automatic long_hit_run();
        drain();
        cfg_write(REG_TARGET_RATE, 40'd1 << $urandom_range(16, 39));
        cfg_write(REG_PRECISION, 40'hFFFF);
        cfg_write(REG_START_GAP, pick_setting(REG_START_GAP));
        repeat ($urandom_range(256, 270)) send_report(near_one_rate(), 1'b0, NO_EXP);
        send_report(any_rate(), 1'b0, NO_EXP);
    endtask

    task automatic random_segment();
        int unsigned seg_end;
        logic [CFG_IDX_W-1:0] idx;
        drain();
        repeat ($urandom_range(1, 3)) begin
            idx = CFG_IDX_W'($urandom_range(3));
            cfg_write(idx, pick_setting(idx));
        end
        seg_end = n_sent + $urandom_range(15, 50);
        while (n_sent < seg_end) begin
            repeat (($urandom_range(3) == 0) ? 0 : $urandom_range(1, 7))
                send_report(near_one_rate(), 1'b0, NO_EXP);
            send_report(any_rate(), 1'b0, NO_EXP);
        end
    endtask

    initial begin
        int unsigned phase_end;
        repeat (3) @(negedge aclk);
        aresetn <= 1'b1;

        for (int i = 0; i < N_DIR; i++) begin
            if (DIR_ROWS[i].kind == ROW_WRITE) begin
                drain();
                cfg_write(DIR_ROWS[i].idx, DIR_ROWS[i].data);
            end else begin
                send_report(DIR_ROWS[i].data[RATE_W-1:0], DIR_ROWS[i].typed, DIR_ROWS[i].res);
            end
        end

        for (int ph = 0; ph < 3; ph++) begin
            case (ph)
                0: begin
                    tx_idle_pct = 8;
                    rx_idle_pct = 79;
                end
                1: begin
                    tx_idle_pct = 79;
                    rx_idle_pct = 8;
                end
                default: begin
                    tx_idle_pct = 0;
                    rx_idle_pct = 0;
                end
            endcase
            phase_end = n_sent + PHASE_ITEMS;
            if (ph != 1)
                long_hit_run();
            while (n_sent < phase_end) random_segment();
        end

        s_tvalid <= 1'b0;
        while (pending_results.size() != 0) @(negedge aclk);
        repeat (TAIL_CYCLES) @(posedge aclk);
        if (mismatch_count == 0)
            $display("tb_send_rate_gap_adjuster_core: done, clean");
        else
            $display("tb_send_rate_gap_adjuster_core: done, errors");
        $finish;
    end

endmodule
